@@ sv/bsd_pkg.sv @@
// Shared types, widths and register codes for the 2x2 box downsampler.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bsd_pkg;

    localparam int CH_W      = 8;
    localparam int SUM_W     = CH_W + 1;
    localparam int PIX_W     = 3 * CH_W;
    localparam int PAIR_W    = 3 * SUM_W;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_COLUMNS_DEF = 2048;
    localparam int MAX_ROWS_DEF    = 2048;

    localparam logic [CFG_W-1:0] SRC_COLUMNS_RST = 12'd1280;
    localparam logic [CFG_W-1:0] SRC_ROWS_RST    = 12'd960;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ROWS    = 2'd1;

    typedef struct packed {
        logic odd_col;
        logic odd_row;
        logic last_blk;
    } t_pos_info;

    function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned limit);
        if (v == '0) begin
            return 1;
        end
        if (32'(v) > limit) begin
            return limit;
        end
        return 32'(v);
    endfunction

endpackage

`default_nettype wire

@@ sv/bsd_pix_if.sv @@
// Source pixel channel: valid/ready handshake with one RGB888 item.
// Depends on bsd_pkg for the channel width.
`timescale 1ns / 1ps
`default_nettype none

interface bsd_pix_if
    import bsd_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;

    modport source (output valid, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

`default_nettype wire

@@ sv/bsd_blk_if.sv @@
// Result channel: valid/ready handshake with one averaged RGB888 item and end flag.
// Depends on bsd_pkg for the channel width.
`timescale 1ns / 1ps
`default_nettype none

interface bsd_blk_if
    import bsd_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_done;

    modport source (output valid, out_red, out_green, out_blue, frame_done, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_done, output ready);
endinterface

`default_nettype wire

@@ sv/bsd_line_mem.sv @@
// Line store of horizontal pair sums: one write port, one read port, registered read.
// Depends on bsd_pkg for the entry width.
`timescale 1ns / 1ps
`default_nettype none

module bsd_line_mem
    import bsd_pkg::*;
#(
    parameter int DEPTH = MAX_COLUMNS_DEF / 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [PAIR_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [PAIR_W-1:0] o_rdata
);

    logic [PAIR_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/bsd_raster_pos.sv @@
// Raster position tracker: column and row counters, slot index and block flags.
// Depends on bsd_pkg for the position info struct.
`timescale 1ns / 1ps
`default_nettype none

module bsd_raster_pos
    import bsd_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int CW          = $clog2(MAX_COLUMNS + 1),
    parameter int RW          = $clog2(MAX_ROWS + 1),
    parameter int SW          = (MAX_COLUMNS / 2 > 1) ? $clog2(MAX_COLUMNS / 2) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_restart,
    input  wire logic          i_advance,
    input  wire logic [CW-1:0] i_cols,
    input  wire logic [RW-1:0] i_rows,
    output t_pos_info          o_info,
    output logic      [SW-1:0] o_slot
);

    localparam int CPW = $clog2(MAX_COLUMNS);
    localparam int RPW = $clog2(MAX_ROWS);

    logic [CPW-1:0] r_col, n_col;
    logic [RPW-1:0] r_row, n_row;
    logic           w_col_end;
    logic           w_row_end;
    logic [CW-1:0]  w_last_col;
    logic [RW-1:0]  w_last_row;

    assign w_col_end  = (CW'(r_col) == (i_cols - CW'(1)));
    assign w_row_end  = (RW'(r_row) == (i_rows - RW'(1)));
    assign w_last_col = {i_cols[CW-1:1], 1'b0} - CW'(1);
    assign w_last_row = {i_rows[RW-1:1], 1'b0} - RW'(1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (i_advance) begin
            if (w_col_end) begin
                n_col = '0;
                n_row = w_row_end ? '0 : r_row + RPW'(1);
            end else begin
                n_col = r_col + CPW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_info.odd_col  = r_col[0];
    assign o_info.odd_row  = r_row[0];
    assign o_info.last_blk = (CW'(r_col) == w_last_col) && (RW'(r_row) == w_last_row);
    assign o_slot          = SW'(r_col >> 1);

endmodule

`default_nettype wire

@@ sv/box_downsample_2x2_rgb.sv @@
// Top level of the 2x2 box downsampler: config registers, pair sums and output stage.
// Depends on bsd_pkg, bsd_pix_if, bsd_blk_if, bsd_raster_pos and bsd_line_mem.
`timescale 1ns / 1ps
`default_nettype none

// Halves an RGB888 raster frame in both directions; each result channel is the
// truncated mean of a 2x2 source block. One source item is taken every clock
// cycle, sustained, as long as the result side keeps up; the odd-row, odd-column
// item that completes a block passes a pair stage, then the output stage. Even rows
// write horizontal pair sums to a line store of MAX_COLUMNS/2 entries and odd rows
// read them back; that store's single write and single read port, one access per
// item, set the rate. An odd last column or row is consumed without a result.
// Writing either size register restarts the frame at row 0, column 0.
module box_downsample_2x2_rgb
    import bsd_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    bsd_pix_if.sink                   i_pix,
    bsd_blk_if.source                 o_pix
);

    localparam int CW         = $clog2(MAX_COLUMNS + 1);
    localparam int RW         = $clog2(MAX_ROWS + 1);
    localparam int LINE_DEPTH = MAX_COLUMNS / 2;
    localparam int SW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic [CW-1:0]     r_cols;
    logic [RW-1:0]     r_rows;
    logic              w_restart;
    logic              w_adv;
    logic              w_accept;
    t_pos_info         w_info;
    logic [SW-1:0]     w_slot;
    logic [PIX_W-1:0]  r_held;
    logic [SUM_W-1:0]  w_sum_r, w_sum_g, w_sum_b;
    logic [PAIR_W-1:0] w_pair;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [PAIR_W-1:0] w_mem_rdata;
    logic              r_s1_valid;
    logic [PAIR_W-1:0] r_s1_pair;
    logic              r_s1_last;
    logic [SUM_W:0]    w_tot_r, w_tot_g, w_tot_b;
    logic              r_out_valid;
    logic [CH_W-1:0]   r_out_red, r_out_green, r_out_blue;
    logic              r_out_done;

    assign w_restart = i_cfg_we &&
                       ((i_cfg_idx == CFG_SRC_COLUMNS) || (i_cfg_idx == CFG_SRC_ROWS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CW'(eff_size(SRC_COLUMNS_RST, MAX_COLUMNS));
            r_rows <= RW'(eff_size(SRC_ROWS_RST, MAX_ROWS));
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SRC_COLUMNS) begin
                r_cols <= CW'(eff_size(i_cfg_data, MAX_COLUMNS));
            end
            if (i_cfg_idx == CFG_SRC_ROWS) begin
                r_rows <= RW'(eff_size(i_cfg_data, MAX_ROWS));
            end
        end
    end

    assign w_adv       = !r_out_valid || o_pix.ready;
    assign i_pix.ready = w_adv;
    assign w_accept    = i_pix.valid && w_adv;

    bsd_raster_pos #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .CW          (CW),
        .RW          (RW),
        .SW          (SW)
    ) u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_restart),
        .i_advance (w_accept),
        .i_cols    (r_cols),
        .i_rows    (r_rows),
        .o_info    (w_info),
        .o_slot    (w_slot)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_info.odd_col) begin
            r_held <= {i_pix.in_red, i_pix.in_green, i_pix.in_blue};
        end
    end

    assign w_sum_r = {1'b0, r_held[PIX_W-1 -: CH_W]}  + {1'b0, i_pix.in_red};
    assign w_sum_g = {1'b0, r_held[2*CH_W-1 -: CH_W]} + {1'b0, i_pix.in_green};
    assign w_sum_b = {1'b0, r_held[CH_W-1:0]}         + {1'b0, i_pix.in_blue};
    assign w_pair  = {w_sum_r, w_sum_g, w_sum_b};

    assign w_mem_we = w_accept && w_info.odd_col && !w_info.odd_row;
    assign w_mem_re = w_accept && w_info.odd_col && w_info.odd_row;

    bsd_line_mem #(
        .DEPTH (LINE_DEPTH),
        .AW    (SW)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_slot),
        .i_wdata (w_pair),
        .i_re    (w_mem_re),
        .i_raddr (w_slot),
        .o_rdata (w_mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_mem_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_re) begin
            r_s1_pair <= w_pair;
            r_s1_last <= w_info.last_blk;
        end
    end

    assign w_tot_r = {1'b0, w_mem_rdata[PAIR_W-1 -: SUM_W]}  + {1'b0, r_s1_pair[PAIR_W-1 -: SUM_W]};
    assign w_tot_g = {1'b0, w_mem_rdata[2*SUM_W-1 -: SUM_W]} + {1'b0, r_s1_pair[2*SUM_W-1 -: SUM_W]};
    assign w_tot_b = {1'b0, w_mem_rdata[SUM_W-1:0]}          + {1'b0, r_s1_pair[SUM_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_out_red   <= w_tot_r[SUM_W:2];
            r_out_green <= w_tot_g[SUM_W:2];
            r_out_blue  <= w_tot_b[SUM_W:2];
            r_out_done  <= r_s1_last;
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.out_red    = r_out_red;
    assign o_pix.out_green  = r_out_green;
    assign o_pix.out_blue   = r_out_blue;
    assign o_pix.frame_done = r_out_done;

endmodule

`default_nettype wire

@@ sv/bsd_checker.sv @@
// Port-level checks for the 2x2 box downsampler and the bind that attaches them.
// Depends on bsd_pkg and the top level box_downsample_2x2_rgb.
`timescale 1ns / 1ps
`default_nettype none

module bsd_checker
    import bsd_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [PIX_W:0]   i_out_data
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result item changed while stalled");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with an empty output stage");

    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_in_acc, 2))
        else $error("result item without a completing source item");

endmodule

bind box_downsample_2x2_rgb bsd_checker u_bsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_data  ({o_pix.frame_done, o_pix.out_red, o_pix.out_green, o_pix.out_blue})
);

`default_nettype wire

@@ bench/box_downsample_2x2_rgb_tb.sv @@
// Self-checking bench for box_downsample_2x2_rgb: drives raster pixel items with random gaps,
// predicts each 2x2 block mean in step and checks every result item in order.
// Depends on bsd_pkg, bsd_pix_if, bsd_blk_if and the block itself.
`timescale 1ns / 1ps

module box_downsample_2x2_rgb_tb;
    import bsd_pkg::*;

    localparam int unsigned LINE_SLOTS   = MAX_COLUMNS_DEF / 2;
    localparam int unsigned RANDOM_ITEMS = 1020;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_pair;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            done;
    } t_mean;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    bsd_pix_if pix_ch ();
    bsd_blk_if blk_ch ();

    box_downsample_2x2_rgb #(
        .MAX_COLUMNS(MAX_COLUMNS_DEF),
        .MAX_ROWS   (MAX_ROWS_DEF)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_pix     (pix_ch),
        .o_pix     (blk_ch)
    );

    // Mirror of the block's registers and frame state
    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_reg;
    int unsigned      cur_row;
    int unsigned      cur_col;
    t_rgb             held_px;
    t_pair            pair_line [LINE_SLOTS];

    t_rgb        pixel_q [$];
    t_mean       block_mean_q [$];
    t_mean       next_mean;
    t_mean       exp_mean;
    int unsigned fault_count;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned ready_mode;
    int unsigned mode_timer;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned top);
        int unsigned n;
        n = v;
        if (n == 0) begin
            n = 1;
        end else if (n > top) begin
            n = top;
        end
        return n;
    endfunction

    function automatic bit shrink_pixel(input t_rgb px, output t_mean res);
        int unsigned    ncols;
        int unsigned    nrows;
        int unsigned    slot;
        t_pair          ps;
        t_pair          above;
        logic [SUM_W:0] tr;
        logic [SUM_W:0] tg;
        logic [SUM_W:0] tb;
        bit             got;
        ncols = clamp_size(cols_reg, MAX_COLUMNS_DEF);
        nrows = clamp_size(rows_reg, MAX_ROWS_DEF);
        got   = 1'b0;
        res   = '0;
        if (cur_col % 2 == 0) begin
            held_px = px;
        end else begin
            ps.red   = {1'b0, held_px.red}   + {1'b0, px.red};
            ps.green = {1'b0, held_px.green} + {1'b0, px.green};
            ps.blue  = {1'b0, held_px.blue}  + {1'b0, px.blue};
            slot = cur_col / 2;
            if (cur_row % 2 == 0) begin
                pair_line[slot] = ps;
            end else begin
                above = pair_line[slot];
                tr = {1'b0, above.red}   + {1'b0, ps.red};
                tg = {1'b0, above.green} + {1'b0, ps.green};
                tb = {1'b0, above.blue}  + {1'b0, ps.blue};
                res.red   = tr[SUM_W:2];
                res.green = tg[SUM_W:2];
                res.blue  = tb[SUM_W:2];
                res.done  = (cur_row == (nrows & ~32'd1) - 1) &&
                            (cur_col == (ncols & ~32'd1) - 1);
                got = 1'b1;
            end
        end
        cur_col++;
        if (cur_col >= ncols) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= nrows) begin
                cur_row = 0;
            end
        end
        return got;
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return CFG_W'($urandom_range(MAX_COLUMNS_DEF + 1, 4095));
            2:       return CFG_W'(MAX_COLUMNS_DEF);
            3:       return '1;
            4:       return CFG_W'(1);
            default: return CFG_W'($urandom_range(2, 10));
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_SRC_COLUMNS || idx == CFG_SRC_ROWS) begin
            if (idx == CFG_SRC_COLUMNS) begin
                cols_reg = val;
            end else begin
                rows_reg = val;
            end
            cur_row = 0;
            cur_col = 0;
            held_px = '0;
        end
    endtask

    task automatic cfg_done();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pixel_q.size() != 0 || pix_ch.valid || block_mean_q.size() != 0);
    endtask

    task automatic settle();
        wait_idle();
        repeat (6) @(posedge i_clk);
    endtask

    task automatic feed(input int unsigned n, input int unsigned flavor);
        logic [CH_W-1:0] ch [3];
        repeat (n) begin
            for (int k = 0; k < 3; k++) begin
                case (flavor)
                    0:       ch[k] = CH_W'($urandom_range(0, 255));
                    1:       ch[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    2:       ch[k] = CH_W'($urandom_range(240, 255));
                    default: ch[k] = CH_W'($urandom_range(0, 15));
                endcase
            end
            pixel_q.push_back(t_rgb'{ch[0], ch[1], ch[2]});
        end
    endtask

    // Sender: bursts of items separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                if (shrink_pixel(t_rgb'{pix_ch.in_red, pix_ch.in_green, pix_ch.in_blue},
                                 next_mean)) begin
                    block_mean_q.push_back(next_mean);
                end
            end
            if (!pix_ch.valid || pix_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    pix_ch.valid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    {pix_ch.in_red, pix_ch.in_green, pix_ch.in_blue} <= pixel_q.pop_front();
                    pix_ch.valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    pix_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern whose mode is redrawn when its timer runs out
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blk_ch.ready <= 1'b0;
        end else begin
            if (mode_timer == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_timer = $urandom_range(50, 400);
            end else begin
                mode_timer--;
            end
            if (stall_left != 0) begin
                stall_left--;
                blk_ch.ready <= 1'b0;
            end else begin
                blk_ch.ready <= 1'b1;
                case (ready_mode)
                    1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
                    2: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 20);
                    3: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 20);
                    default: ;
                endcase
            end
        end
    end

    // Compare each result item with the oldest predicted block mean
    always @(posedge i_clk) begin
        if (i_rst_n && blk_ch.valid && blk_ch.ready) begin
            if (block_mean_q.size() == 0) begin
                fault_count = fault_count + 1;
                if (fault_count <= 10) begin
                    $display("%0t: unexpected result r=%0d g=%0d b=%0d done=%0b", $realtime,
                             blk_ch.out_red, blk_ch.out_green, blk_ch.out_blue,
                             blk_ch.frame_done);
                end
            end else begin
                exp_mean = block_mean_q.pop_front();
                if (blk_ch.out_red !== exp_mean.red || blk_ch.out_green !== exp_mean.green ||
                    blk_ch.out_blue !== exp_mean.blue ||
                    blk_ch.frame_done !== exp_mean.done) begin
                    fault_count = fault_count + 1;
                    if (fault_count <= 10) begin
                        $display("%0t: mismatch exp r=%0d g=%0d b=%0d done=%0b", $realtime,
                                 exp_mean.red, exp_mean.green, exp_mean.blue,
                                 exp_mean.done);
                        $display("%0t:          got r=%0d g=%0d b=%0d done=%0b", $realtime,
                                 blk_ch.out_red, blk_ch.out_green, blk_ch.out_blue,
                                 blk_ch.frame_done);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned      random_items;
        int unsigned      frame_len;
        int unsigned      n;
        int unsigned      split;
        int unsigned      flavor;
        logic [CFG_W-1:0] cols_val;
        logic [CFG_W-1:0] rows_val;

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_SRC_COLUMNS;
        i_cfg_data       = '0;
        pix_ch.valid     = 1'b0;
        pix_ch.in_red    = '0;
        pix_ch.in_green  = '0;
        pix_ch.in_blue   = '0;
        blk_ch.ready     = 1'b0;
        cols_reg         = SRC_COLUMNS_RST;
        rows_reg         = SRC_ROWS_RST;
        cur_row          = 0;
        cur_col          = 0;
        held_px          = '0;
        fault_count      = 0;
        cycle_count      = 0;
        burst_left       = 0;
        gap_left         = 0;
        stall_left       = 0;
        ready_mode       = 0;
        mode_timer       = 0;
        random_items     = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Two columns against the reset row count: full-scale block, no frame end
        cfg_write(CFG_SRC_COLUMNS, 12'd2);
        cfg_done();
        repeat (4) pixel_q.push_back(t_rgb'{8'hFF, 8'hFF, 8'hFF});
        settle();
        cfg_write(CFG_SRC_ROWS, 12'd2);
        cfg_done();
        repeat (4) pixel_q.push_back(t_rgb'{8'h00, 8'h00, 8'h00});
        // Truncation of the mean
        pixel_q.push_back(t_rgb'{8'd3, 8'd1, 8'd255});
        pixel_q.push_back(t_rgb'{8'd3, 8'd0, 8'd255});
        pixel_q.push_back(t_rgb'{8'd3, 8'd0, 8'd255});
        pixel_q.push_back(t_rgb'{8'd2, 8'd0, 8'd254});
        // Zero columns acts as one: nothing comes out
        settle();
        cfg_write(CFG_SRC_COLUMNS, 12'd0);
        cfg_done();
        feed(3, 0);
        // Odd sizes: the last column and row are dropped
        settle();
        cfg_write(CFG_SRC_COLUMNS, 12'd3);
        cfg_write(CFG_SRC_ROWS, 12'd3);
        cfg_done();
        feed(9, 0);

        while (random_items < RANDOM_ITEMS) begin
            settle();
            cols_val = pick_size();
            rows_val = pick_size();
            case ($urandom_range(0, 4))
                0: cfg_write(CFG_SRC_COLUMNS, cols_val);
                1: cfg_write(CFG_SRC_ROWS, rows_val);
                default: begin
                    cfg_write(CFG_SRC_COLUMNS, cols_val);
                    cfg_write(CFG_SRC_ROWS, rows_val);
                end
            endcase
            cfg_done();
            frame_len = clamp_size(cols_reg, MAX_COLUMNS_DEF) * clamp_size(rows_reg, MAX_ROWS_DEF);
            if (frame_len > 400) begin
                n = $urandom_range(1, 60);
            end else if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, frame_len + 12);
            end else begin
                n = frame_len * $urandom_range(1, 3);
            end
            flavor = $urandom_range(0, 7);
            if (flavor > 3) begin
                flavor = 0;
            end
            if (n > 1 && $urandom_range(0, 4) == 0) begin
                // Unused register index mid-frame: the frame must carry on
                split = $urandom_range(1, n - 1);
                feed(split, flavor);
                settle();
                cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_W'($urandom));
                cfg_done();
                feed(n - split, flavor);
            end else begin
                feed(n, flavor);
            end
            random_items += n;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ box_downsample_2x2_rgb.f @@
sv/bsd_pkg.sv
sv/bsd_pix_if.sv
sv/bsd_blk_if.sv
sv/bsd_line_mem.sv
sv/bsd_raster_pos.sv
sv/box_downsample_2x2_rgb.sv
sv/bsd_checker.sv
bench/box_downsample_2x2_rgb_tb.sv
